[rtl/core/expression_tokenizer_longest_match_macros.svh]
// Assertion helpers for the tokenizer checker.
// Both sample on the rising edge of clock; the first is disabled in reset.
`ifndef EXPRESSION_TOKENIZER_LONGEST_MATCH_MACROS_SVH
`define EXPRESSION_TOKENIZER_LONGEST_MATCH_MACROS_SVH

`define ETLM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`define ETLM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

[rtl/core/etlm_pkg.sv]
`timescale 1ns / 1ps

package etlm_pkg;

   localparam int POS_BITS_DEF = 16;
   localparam int MAX_TOKEN    = 128;
   localparam int NUM_DFA      = 9;
   localparam int NUM_OPS      = 6;

   localparam logic [15:0]        LEN_TOP   = 16'hFFFF;
   localparam logic [NUM_DFA-1:0] ALIVE_ALL = '1;

   // Token kinds; KIND_SPACE never leaves the block
   localparam logic [3:0] KIND_NONE   = 4'd0;
   localparam logic [3:0] KIND_NUMBER = 4'd1;
   localparam logic [3:0] KIND_IDENT  = 4'd2;
   localparam logic [3:0] KIND_PLUS   = 4'd3;
   localparam logic [3:0] KIND_SPACE  = 4'd9;

   // Number recogniser states
   localparam logic [2:0] NUM_START = 3'd0;
   localparam logic [2:0] NUM_DOT   = 3'd1;
   localparam logic [2:0] NUM_FRAC  = 3'd2;
   localparam logic [2:0] NUM_EXP   = 3'd3;
   localparam logic [2:0] NUM_SIGN  = 3'd4;
   localparam logic [2:0] NUM_EXPD  = 3'd5;

   // Operator characters in kind order: + - * / ( )
   localparam logic [7:0] OP_CHARS [NUM_OPS] = '{8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29};

   typedef enum logic {
      ST_SCAN,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic pop;
      logic commit;
      logic set_stop;
      logic emit;
      logic close;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pend_empty;
      logic end_seen;
      logic stopped;
      logic adv_ok;
      logic best_none;
      logic best_space;
      logic scan_zero;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/core/etlm_req_if.sv]
`timescale 1ns / 1ps

interface etlm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       text_end;

   modport source (output valid, output text_byte, output text_end, input ready);
   modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

[rtl/core/etlm_rsp_if.sv]
`timescale 1ns / 1ps

interface etlm_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic        too_long;
   logic        closing;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output too_long, output closing, input ready);
   modport sink   (input valid, input token_kind, input token_start,
                   input token_length, input too_long, input closing, output ready);
endinterface

[rtl/core/expression_tokenizer_longest_match.sv]
// Longest-match tokenizer for arithmetic expression text.
// req_bus carries one text byte per beat, with text_end on the last byte of a text.
// rsp_bus carries one token per beat: kind, start offset, length, a long-token
// flag, and a closing flag on the single final beat of each text.
// Whitespace is matched and dropped; an unrecognised byte stops tokenizing and
// later bytes are swallowed until text_end.
// Throughput: one byte per cycle while the current match keeps extending. Ending
// a token emits it, holding while a stalled result occupies the output register,
// and then the ending byte and up to two overrun bytes are fed again from the
// replay queue at one byte per cycle.
// A token appears on rsp_bus the cycle after the controller emits it, and the
// cycle after the beat that ended the match at the earliest. After text_end
// the pending scan is flushed token by token, with the replays in between, then
// the closing beat follows.
// Reset clears the scan, the offset counter and the result valid flag; no beat
// is accepted in the reset cycle, and a shown beat is dropped by reset.
// A stalled result holds in the output register; the block keeps scanning
// until it must emit a further token, then holds and drops req_bus.ready.
`timescale 1ns / 1ps

module expression_tokenizer_longest_match
   import etlm_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   etlm_req_if.sink   req_bus,
   etlm_rsp_if.source rsp_bus
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   etlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   etlm_dpath #(
      .POS_BITS (POS_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .text_byte    (req_bus.text_byte),
      .text_end     (req_bus.text_end),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid    (rsp_bus.valid),
      .token_kind   (rsp_bus.token_kind),
      .token_start  (rsp_bus.token_start),
      .token_length (rsp_bus.token_length),
      .too_long     (rsp_bus.too_long),
      .closing      (rsp_bus.closing)
   );

endmodule

[rtl/core/etlm_ctrl.sv]
`timescale 1ns / 1ps

module etlm_ctrl
   import etlm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SCAN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SCAN: begin
            if (status.end_seen && status.pend_empty) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.stopped && !status.scan_zero) begin
               if (!status.best_none && (status.best_space || status.out_free)) begin
                  state_in = ST_SCAN;
               end
            end else if (status.out_free) begin
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_SCAN;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_SCAN: begin
            req_ready  = !reset && status.pend_empty && !status.end_seen;
            cmd.accept = req_ready && req_valid;
            if (!status.pend_empty || cmd.accept) begin
               if (status.stopped) begin
                  // drop bytes until end of text
                  cmd.pop = 1'b1;
               end else if (status.adv_ok) begin
                  cmd.pop    = 1'b1;
                  cmd.commit = 1'b1;
               end else if (status.best_none) begin
                  cmd.pop      = 1'b1;
                  cmd.set_stop = 1'b1;
               end else if (status.best_space || status.out_free) begin
                  // head stays queued and is fed again after the overrun
                  cmd.emit = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.stopped && !status.scan_zero) begin
               if (status.best_none) begin
                  cmd.set_stop = 1'b1;
               end else if (status.best_space || status.out_free) begin
                  cmd.emit = 1'b1;
               end
            end else if (status.out_free) begin
               cmd.close = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

[rtl/core/etlm_dpath.sv]
`timescale 1ns / 1ps

module etlm_dpath
   import etlm_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [7:0]    text_byte,
   input  logic          text_end,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [3:0]    token_kind,
   output logic [15:0]   token_start,
   output logic [15:0]   token_length,
   output logic          too_long,
   output logic          closing
);

   localparam int START_BITS = (POS_BITS < 16) ? POS_BITS : 16;

   // scan state
   logic [2:0]          num_st_ff, num_st_in;
   logic [NUM_OPS:0]    small_ff, small_in;
   logic [NUM_DFA-1:0]  alive_ff, alive_in;
   logic [3:0]          best_kind_ff, best_kind_in;
   logic [15:0]         best_len_ff, best_len_in;
   logic [15:0]         scan_len_ff, scan_len_in;
   logic [7:0]          rep_ff [2];
   logic [7:0]          rep_in [2];
   logic [1:0]          rep_cnt_ff, rep_cnt_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic                stopped_ff, stopped_in;
   logic                end_ff, end_in;

   // bytes waiting to be fed, oldest first
   logic [7:0]          pend_ff [3];
   logic [7:0]          pend_in [3];
   logic [1:0]          pend_cnt_ff, pend_cnt_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          kind_ff, kind_in;
   logic [15:0]         tstart_ff, tstart_in;
   logic [15:0]         tlen_ff, tlen_in;
   logic                long_ff, long_in;
   logic                close_ff, close_in;

   // one step of all recognisers on the head byte
   logic [7:0]          head;
   logic                is_digit, is_alpha, num_ok;
   logic [2:0]          num_next;
   logic [NUM_DFA-1:0]  adv_alive;
   logic [2:0]          adv_num;
   logic [NUM_OPS:0]    adv_small;
   logic                adv_fin;
   logic [3:0]          adv_kind;
   logic [15:0]         scan_inc;

   logic [7:0]          q0, q1, q2;
   logic [1:0]          qlen;
   logic [POS_BITS-1:0] emit_start;
   logic [15:0]         start16;
   logic                load_tok;

   assign head     = (pend_cnt_ff == 2'd0) ? text_byte : pend_ff[0];
   assign is_digit = (head >= 8'h30) && (head <= 8'h39);
   assign is_alpha = ((head >= 8'h61) && (head <= 8'h7A)) ||
                     ((head >= 8'h41) && (head <= 8'h5A)) || (head == 8'h5F);

   always_comb begin
      num_ok   = 1'b0;
      num_next = NUM_START;
      case (num_st_ff)
         NUM_START: begin
            if (is_digit) begin
               num_ok = 1'b1; num_next = NUM_START;
            end else if (head == 8'h2E) begin
               num_ok = 1'b1; num_next = NUM_DOT;
            end
         end
         NUM_DOT: begin
            if (is_digit) begin
               num_ok = 1'b1; num_next = NUM_FRAC;
            end
         end
         NUM_FRAC: begin
            if (is_digit) begin
               num_ok = 1'b1; num_next = NUM_FRAC;
            end else if ((head == 8'h65) || (head == 8'h45)) begin
               num_ok = 1'b1; num_next = NUM_EXP;
            end
         end
         NUM_EXP: begin
            if (is_digit) begin
               num_ok = 1'b1; num_next = NUM_EXPD;
            end else if ((head == 8'h2B) || (head == 8'h2D)) begin
               num_ok = 1'b1; num_next = NUM_SIGN;
            end
         end
         NUM_SIGN, NUM_EXPD: begin
            if (is_digit) begin
               num_ok = 1'b1; num_next = NUM_EXPD;
            end
         end
         default: num_ok = 1'b0;
      endcase
   end

   // later recognisers override earlier ones on a tie
   always_comb begin
      adv_alive = '0;
      adv_num   = num_st_ff;
      adv_small = small_ff;
      adv_fin   = 1'b0;
      adv_kind  = KIND_NONE;
      if (alive_ff[0] && ((head == 8'h20) || (head == 8'h0A) || (head == 8'h09))) begin
         adv_alive[0] = 1'b1;
         adv_fin      = 1'b1;
         adv_kind     = KIND_SPACE;
      end
      if (alive_ff[1] && num_ok) begin
         adv_alive[1] = 1'b1;
         adv_num      = num_next;
         if ((num_next == NUM_START) || (num_next == NUM_FRAC) || (num_next == NUM_EXPD)) begin
            adv_fin  = 1'b1;
            adv_kind = KIND_NUMBER;
         end
      end
      if (alive_ff[2] && (is_alpha ||
          (small_ff[0] && (is_digit || (head == 8'h2E) || (head == 8'h3A))))) begin
         adv_alive[2] = 1'b1;
         adv_small[0] = 1'b1;
         adv_fin      = 1'b1;
         adv_kind     = KIND_IDENT;
      end
      for (int k = 0; k < NUM_OPS; k++) begin
         if (alive_ff[3+k] && !small_ff[1+k] && (head == OP_CHARS[k])) begin
            adv_alive[3+k] = 1'b1;
            adv_small[1+k] = 1'b1;
            adv_fin        = 1'b1;
            adv_kind       = KIND_PLUS + 4'(k);
         end
      end
   end

   assign scan_inc = (scan_len_ff == LEN_TOP) ? scan_len_ff : scan_len_ff + 16'd1;

   // queue seen this cycle: pending bytes, or the beat taken now
   assign q0   = cmd.accept ? text_byte : pend_ff[0];
   assign q1   = pend_ff[1];
   assign q2   = pend_ff[2];
   assign qlen = cmd.accept ? 2'd1 : pend_cnt_ff;

   // queued bytes are the most recent ones; the overrun sits just before them
   assign emit_start = pos_ff - POS_BITS'(pend_cnt_ff) - POS_BITS'(rep_cnt_ff);
   assign start16    = 16'(start_ff[START_BITS-1:0]);
   assign load_tok   = cmd.emit && (best_kind_ff != KIND_SPACE);

   always_comb begin
      num_st_in    = num_st_ff;
      small_in     = small_ff;
      alive_in     = alive_ff;
      best_kind_in = best_kind_ff;
      best_len_in  = best_len_ff;
      scan_len_in  = scan_len_ff;
      rep_in[0]    = rep_ff[0];
      rep_in[1]    = rep_ff[1];
      rep_cnt_in   = rep_cnt_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      stopped_in   = stopped_ff;
      end_in       = end_ff;
      pend_in[0]   = q0;
      pend_in[1]   = q1;
      pend_in[2]   = q2;
      pend_cnt_in  = qlen;

      if (cmd.accept) begin
         pos_in = pos_ff + POS_BITS'(1);
         end_in = text_end;
      end

      if (cmd.commit) begin
         alive_in    = adv_alive;
         num_st_in   = adv_num;
         small_in    = adv_small;
         scan_len_in = scan_inc;
         if (adv_fin) begin
            best_kind_in = adv_kind;
            best_len_in  = scan_inc;
            rep_cnt_in   = 2'd0;
         end else if (rep_cnt_ff < 2'd2) begin
            rep_in[rep_cnt_ff[0]] = head;
            rep_cnt_in            = rep_cnt_ff + 2'd1;
         end
      end

      if (cmd.pop) begin
         pend_in[0]  = q1;
         pend_in[1]  = q2;
         pend_in[2]  = q2;
         pend_cnt_in = qlen - 2'd1;
      end else if (cmd.emit) begin
         // restart from the overrun, then the held bytes
         num_st_in    = NUM_START;
         small_in     = '0;
         alive_in     = ALIVE_ALL;
         best_kind_in = KIND_NONE;
         best_len_in  = '0;
         scan_len_in  = '0;
         rep_cnt_in   = 2'd0;
         start_in     = emit_start;
         pend_cnt_in  = qlen + rep_cnt_ff;
         case (rep_cnt_ff)
            2'd1: begin
               pend_in[0] = rep_ff[0];
               pend_in[1] = q0;
               pend_in[2] = q1;
            end
            2'd2: begin
               pend_in[0] = rep_ff[0];
               pend_in[1] = rep_ff[1];
               pend_in[2] = q0;
            end
            default: begin
               pend_in[0] = q0;
               pend_in[1] = q1;
               pend_in[2] = q2;
            end
         endcase
      end

      if (cmd.set_stop) begin
         stopped_in = 1'b1;
      end

      if (cmd.close) begin
         num_st_in    = NUM_START;
         small_in     = '0;
         alive_in     = ALIVE_ALL;
         best_kind_in = KIND_NONE;
         best_len_in  = '0;
         scan_len_in  = '0;
         rep_cnt_in   = 2'd0;
         start_in     = '0;
         pos_in       = '0;
         stopped_in   = 1'b0;
         end_in       = 1'b0;
         pend_cnt_in  = 2'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      tstart_in    = tstart_ff;
      tlen_in      = tlen_ff;
      long_in      = long_ff;
      close_in     = close_ff;
      if (load_tok) begin
         rsp_valid_in = 1'b1;
         kind_in      = best_kind_ff;
         tstart_in    = start16;
         tlen_in      = best_len_ff;
         long_in      = best_len_ff >= 16'(MAX_TOKEN);
         close_in     = 1'b0;
      end else if (cmd.close) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_NONE;
         tstart_in    = start16;
         tlen_in      = '0;
         long_in      = 1'b0;
         close_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_st_ff    <= NUM_START;
         small_ff     <= '0;
         alive_ff     <= ALIVE_ALL;
         best_kind_ff <= KIND_NONE;
         best_len_ff  <= '0;
         scan_len_ff  <= '0;
         rep_cnt_ff   <= 2'd0;
         pos_ff       <= '0;
         start_ff     <= '0;
         stopped_ff   <= 1'b0;
         end_ff       <= 1'b0;
         pend_cnt_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_st_ff    <= num_st_in;
         small_ff     <= small_in;
         alive_ff     <= alive_in;
         best_kind_ff <= best_kind_in;
         best_len_ff  <= best_len_in;
         scan_len_ff  <= scan_len_in;
         rep_cnt_ff   <= rep_cnt_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         stopped_ff   <= stopped_in;
         end_ff       <= end_in;
         pend_cnt_ff  <= pend_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rep_ff[0]  <= rep_in[0];
      rep_ff[1]  <= rep_in[1];
      pend_ff[0] <= pend_in[0];
      pend_ff[1] <= pend_in[1];
      pend_ff[2] <= pend_in[2];
      kind_ff    <= kind_in;
      tstart_ff  <= tstart_in;
      tlen_ff    <= tlen_in;
      long_ff    <= long_in;
      close_ff   <= close_in;
   end

   assign status.pend_empty = (pend_cnt_ff == 2'd0);
   assign status.end_seen   = end_ff;
   assign status.stopped    = stopped_ff;
   assign status.adv_ok     = |adv_alive;
   assign status.best_none  = (best_kind_ff == KIND_NONE);
   assign status.best_space = (best_kind_ff == KIND_SPACE);
   assign status.scan_zero  = (scan_len_ff == 16'd0);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign token_kind   = kind_ff;
   assign token_start  = tstart_ff;
   assign token_length = tlen_ff;
   assign too_long     = long_ff;
   assign closing      = close_ff;

endmodule

[rtl/core/etlm_checker.sv]
`timescale 1ns / 1ps
`include "expression_tokenizer_longest_match_macros.svh"

module etlm_checker
   import etlm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  token_kind,
   input logic [15:0] token_start,
   input logic [15:0] token_length,
   input logic        too_long,
   input logic        closing
);

   `ETLM_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "result shown right after reset")

   `ETLM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(token_kind) && $stable(token_start) && $stable(token_length) && $stable(too_long) && $stable(closing), "stalled result beat changed")

   `ETLM_ASSERT(a_close_form, rsp_valid && closing |-> token_kind == KIND_NONE && token_length == 16'd0 && !too_long, "closing beat carries a token")

   `ETLM_ASSERT(a_token_form, rsp_valid && !closing |-> token_kind != KIND_NONE && token_kind != KIND_SPACE && token_length != 16'd0 && (too_long == (token_length >= 16'(MAX_TOKEN))), "malformed token beat")

endmodule

bind expression_tokenizer_longest_match etlm_checker u_etlm_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .token_kind   (rsp_bus.token_kind),
   .token_start  (rsp_bus.token_start),
   .token_length (rsp_bus.token_length),
   .too_long     (rsp_bus.too_long),
   .closing      (rsp_bus.closing)
);
